@@ rtl/rotary_encoder_button_qualifier_unit_assert.svh @@
// Assertion macros for the rotary encoder button qualifier
`ifndef ROTARY_ENCODER_BUTTON_QUALIFIER_UNIT_ASSERT_SVH
`define ROTARY_ENCODER_BUTTON_QUALIFIER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define REB_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define REB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/reb_pkg.sv @@
// Shared types and constants for the rotary encoder button qualifier
`default_nettype none
package reb_pkg;

	localparam int TIME_W  = 32;
	localparam int HOLD_W  = 16;
	localparam int DELAY_W = 8;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 5;
	localparam int IDX_W   = 3;

	localparam logic [IDX_W-1:0] REG_TURN_HOLDOFF  = 3'd0;
	localparam logic [IDX_W-1:0] REG_PUSH_HOLDOFF  = 3'd1;
	localparam logic [IDX_W-1:0] REG_LONG_PRESS    = 3'd2;
	localparam logic [IDX_W-1:0] REG_REVERT_WINDOW = 3'd3;
	localparam logic [IDX_W-1:0] REG_STARTUP_DELAY = 3'd4;

	localparam logic [HOLD_W-1:0]  TURN_HOLDOFF_RST  = 16'd50;
	localparam logic [HOLD_W-1:0]  PUSH_HOLDOFF_RST  = 16'd100;
	localparam logic [HOLD_W-1:0]  LONG_PRESS_RST    = 16'd500;
	localparam logic [HOLD_W-1:0]  REVERT_WINDOW_RST = 16'd300;
	localparam logic [DELAY_W-1:0] STARTUP_DELAY_RST = 8'd2;

	typedef struct packed {
		logic [HOLD_W-1:0]  turn_holdoff_ms;
		logic [HOLD_W-1:0]  push_holdoff_ms;
		logic [HOLD_W-1:0]  long_press_ms;
		logic [HOLD_W-1:0]  revert_window_ms;
		logic [DELAY_W-1:0] startup_delay_s;
	} cfg_t;

	typedef struct packed {
		logic              pin_a;
		logic              pin_b;
		logic              button_level;
		logic [TIME_W-1:0] now_ms;
		logic [TIME_W-1:0] uptime_s;
		logic              display_locked;
	} evt_t;

	typedef struct packed {
		logic step_right;
		logic step_left;
		logic nav_right;
		logic nav_left;
		logic press_seen;
		logic push_action;
		logic revert_screen;
		logic release_short;
		logic release_long;
	} res_t;

endpackage
`default_nettype wire

@@ rtl/reb_if.sv @@
// Channel interfaces: pin-change events in, qualified flags out
`default_nettype none
interface reb_evt_if;
	logic                      valid;
	logic                      ready;
	logic                      pin_a;
	logic                      pin_b;
	logic                      button_level;
	logic [reb_pkg::TIME_W-1:0] now_ms;
	logic [reb_pkg::TIME_W-1:0] uptime_s;
	logic                      display_locked;

	modport source(output valid, pin_a, pin_b, button_level, now_ms, uptime_s,
		display_locked, input ready);
	modport sink(input valid, pin_a, pin_b, button_level, now_ms, uptime_s,
		display_locked, output ready);
endinterface

interface reb_res_if;
	logic valid;
	logic ready;
	logic step_right;
	logic step_left;
	logic nav_right;
	logic nav_left;
	logic press_seen;
	logic push_action;
	logic revert_screen;
	logic release_short;
	logic release_long;

	modport source(output valid, step_right, step_left, nav_right, nav_left, press_seen,
		push_action, revert_screen, release_short, release_long, input ready);
	modport sink(input valid, step_right, step_left, nav_right, nav_left, press_seen,
		push_action, revert_screen, release_short, release_long, output ready);
endinterface
`default_nettype wire

@@ rtl/reb_cfg.sv @@
// APB configuration registers
`default_nettype none
module reb_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [reb_pkg::ADDR_W-1:0]  paddr,
	input  logic [reb_pkg::DATA_W-1:0]  pwdata,
	output logic [reb_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output reb_pkg::cfg_t               cfg
);

	reb_pkg::cfg_t           cfg_q;
	logic                    wr_en;
	logic [reb_pkg::IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[reb_pkg::ADDR_W-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.turn_holdoff_ms  <= reb_pkg::TURN_HOLDOFF_RST;
			cfg_q.push_holdoff_ms  <= reb_pkg::PUSH_HOLDOFF_RST;
			cfg_q.long_press_ms    <= reb_pkg::LONG_PRESS_RST;
			cfg_q.revert_window_ms <= reb_pkg::REVERT_WINDOW_RST;
			cfg_q.startup_delay_s  <= reb_pkg::STARTUP_DELAY_RST;
		end else if (wr_en) begin
			unique case (idx)
				reb_pkg::REG_TURN_HOLDOFF:
					cfg_q.turn_holdoff_ms <= pwdata[reb_pkg::HOLD_W-1:0];
				reb_pkg::REG_PUSH_HOLDOFF:
					cfg_q.push_holdoff_ms <= pwdata[reb_pkg::HOLD_W-1:0];
				reb_pkg::REG_LONG_PRESS:
					cfg_q.long_press_ms <= pwdata[reb_pkg::HOLD_W-1:0];
				reb_pkg::REG_REVERT_WINDOW:
					cfg_q.revert_window_ms <= pwdata[reb_pkg::HOLD_W-1:0];
				reb_pkg::REG_STARTUP_DELAY:
					cfg_q.startup_delay_s <= pwdata[reb_pkg::DELAY_W-1:0];
				default: ; // drop writes to unmapped addresses
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			reb_pkg::REG_TURN_HOLDOFF:
				prdata = {{(reb_pkg::DATA_W-reb_pkg::HOLD_W){1'b0}}, cfg_q.turn_holdoff_ms};
			reb_pkg::REG_PUSH_HOLDOFF:
				prdata = {{(reb_pkg::DATA_W-reb_pkg::HOLD_W){1'b0}}, cfg_q.push_holdoff_ms};
			reb_pkg::REG_LONG_PRESS:
				prdata = {{(reb_pkg::DATA_W-reb_pkg::HOLD_W){1'b0}}, cfg_q.long_press_ms};
			reb_pkg::REG_REVERT_WINDOW:
				prdata = {{(reb_pkg::DATA_W-reb_pkg::HOLD_W){1'b0}}, cfg_q.revert_window_ms};
			reb_pkg::REG_STARTUP_DELAY:
				prdata = {{(reb_pkg::DATA_W-reb_pkg::DELAY_W){1'b0}}, cfg_q.startup_delay_s};
			default:
				prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/rotary_encoder_button_qualifier_unit.sv @@
// Top level: encoder step and push button qualifier with APB configuration
//
//   channel   direction  handshake           content
//   evt       in         valid/ready         pin levels, now_ms, uptime_s, lock flag
//   result    out        valid/ready         nine qualified event flags
//   apb       in/out     psel/penable/pready five timing registers
//
// One event a cycle while the result is taken: an event is registered, qualified against the state in
// the next cycle and written to the result register with the state update.
// An accepted event passes through the input register and then the result register.
// Reset clears the state and loads the default timings; no clearing pass.
// A stalled result holds the qualify stage, which then holds evt.ready low.
`default_nettype none
module rotary_encoder_button_qualifier_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	reb_evt_if.sink                    evt,
	reb_res_if.source                  result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [reb_pkg::ADDR_W-1:0] paddr,
	input  logic [reb_pkg::DATA_W-1:0] pwdata,
	output logic [reb_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);

	reb_pkg::cfg_t cfg;

	reb_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	reb_pkg::evt_t evt_s1;
	logic          valid_s1;
	reb_pkg::res_t res_q;
	logic          res_valid_q;

	logic started_q;
	logic last_a_q;
	logic last_b_q;
	logic held_q;
	logic [reb_pkg::TIME_W-1:0] last_right_q;
	logic [reb_pkg::TIME_W-1:0] last_left_q;
	logic [reb_pkg::TIME_W-1:0] last_push_q;

	logic advance;
	logic fire;

	assign advance   = !res_valid_q || result.ready;
	assign fire      = valid_s1 && advance;
	assign evt.ready = !valid_s1 || advance;

	// Qualify logic
	logic go;
	logic a_chg;
	logic step;
	logic acc_right;
	logic acc_left;
	logic press;
	logic release_edge;
	logic push_ok;
	logic revert;
	logic is_long;
	logic [reb_pkg::TIME_W-1:0] d_right;
	logic [reb_pkg::TIME_W-1:0] d_left;
	logic [reb_pkg::TIME_W-1:0] d_push;
	logic [reb_pkg::TIME_W-1:0] new_right;
	logic [reb_pkg::TIME_W-1:0] new_left;
	logic [reb_pkg::TIME_W-1:0] d_rev_right;
	logic [reb_pkg::TIME_W-1:0] d_rev_left;
	logic [reb_pkg::TIME_W-1:0] turn_hold;
	logic [reb_pkg::TIME_W-1:0] push_hold;
	logic [reb_pkg::TIME_W-1:0] long_lim;
	logic [reb_pkg::TIME_W-1:0] rev_win;
	logic [reb_pkg::TIME_W-1:0] start_lim;
	reb_pkg::res_t res_d;

	always_comb begin
		turn_hold = {{(reb_pkg::TIME_W-reb_pkg::HOLD_W){1'b0}}, cfg.turn_holdoff_ms};
		push_hold = {{(reb_pkg::TIME_W-reb_pkg::HOLD_W){1'b0}}, cfg.push_holdoff_ms};
		long_lim  = {{(reb_pkg::TIME_W-reb_pkg::HOLD_W){1'b0}}, cfg.long_press_ms};
		rev_win   = {{(reb_pkg::TIME_W-reb_pkg::HOLD_W){1'b0}}, cfg.revert_window_ms};
		start_lim = {{(reb_pkg::TIME_W-reb_pkg::DELAY_W){1'b0}}, cfg.startup_delay_s};

		go    = (evt_s1.uptime_s > start_lim) || started_q;
		a_chg = evt_s1.pin_a != last_a_q;
		step  = go && a_chg && (evt_s1.pin_b != last_b_q);

		d_right   = evt_s1.now_ms - last_right_q;
		d_left    = evt_s1.now_ms - last_left_q;
		d_push    = evt_s1.now_ms - last_push_q;
		acc_right = step && (evt_s1.pin_a == evt_s1.pin_b) && (d_right > turn_hold);
		acc_left  = step && (evt_s1.pin_a != evt_s1.pin_b) && (d_left > turn_hold);

		// step times taken by this event count for the revert window
		new_right   = acc_right ? evt_s1.now_ms : last_right_q;
		new_left    = acc_left ? evt_s1.now_ms : last_left_q;
		d_rev_right = evt_s1.now_ms - new_right;
		d_rev_left  = evt_s1.now_ms - new_left;

		press        = go && !evt_s1.button_level && !held_q;
		release_edge = go && evt_s1.button_level && held_q;
		push_ok      = press && (d_push > push_hold);
		revert       = press && ((d_rev_left < rev_win) || (d_rev_right < rev_win));
		is_long      = (evt_s1.now_ms < last_push_q) || (d_push > long_lim);

		res_d.step_right    = acc_right;
		res_d.step_left     = acc_left;
		res_d.nav_right     = acc_right && !evt_s1.display_locked;
		res_d.nav_left      = acc_left && !evt_s1.display_locked;
		res_d.press_seen    = press;
		res_d.push_action   = push_ok;
		res_d.revert_screen = revert;
		res_d.release_short = release_edge && !is_long;
		res_d.release_long  = release_edge && is_long;
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			evt_s1.pin_a          <= evt.pin_a;
			evt_s1.pin_b          <= evt.pin_b;
			evt_s1.button_level   <= evt.button_level;
			evt_s1.now_ms         <= evt.now_ms;
			evt_s1.uptime_s       <= evt.uptime_s;
			evt_s1.display_locked <= evt.display_locked;
		end
	end

	// Qualifier state, advanced once per event once the startup delay has passed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q    <= 1'b0;
			last_a_q     <= 1'b0;
			last_b_q     <= 1'b0;
			held_q       <= 1'b0;
			last_right_q <= '0;
			last_left_q  <= '0;
			last_push_q  <= '0;
		end else if (fire && go) begin
			started_q    <= 1'b1;
			last_a_q     <= evt_s1.pin_a;
			last_right_q <= new_right;
			last_left_q  <= new_left;
			if (step) begin
				last_b_q <= evt_s1.pin_b;
			end
			if (press) begin
				held_q <= 1'b1;
			end else if (release_edge) begin
				held_q <= 1'b0;
			end
			if (push_ok) begin
				last_push_q <= evt_s1.now_ms;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_d;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.step_right    = res_q.step_right;
	assign result.step_left     = res_q.step_left;
	assign result.nav_right     = res_q.nav_right;
	assign result.nav_left      = res_q.nav_left;
	assign result.press_seen    = res_q.press_seen;
	assign result.push_action   = res_q.push_action;
	assign result.revert_screen = res_q.revert_screen;
	assign result.release_short = res_q.release_short;
	assign result.release_long  = res_q.release_long;

`include "rotary_encoder_button_qualifier_unit_assert.svh"

	`REB_ASSERT_SAME(a_one_dir, result.valid, !(result.step_right && result.step_left), "both step directions flagged")
	`REB_ASSERT_SAME(a_nav_step, result.valid && (result.nav_right || result.nav_left), (result.nav_right == result.step_right) || (result.nav_left == result.step_left), "navigation without matching step")
	`REB_ASSERT_SAME(a_press_rel, result.valid && result.press_seen, !result.release_short && !result.release_long, "press and release in one event")
	`REB_ASSERT_NEXT(a_held_set, fire && press, held_q && started_q, "press did not set held state")
	`REB_ASSERT_SAME(a_push_press, result.valid && (result.push_action || result.revert_screen), result.press_seen, "push or revert without press")

endmodule
`default_nettype wire
